>>> rtl/wdmc_pkg.sv
// Package for the watchdog timer with magic close: modes, status codes,
// register indexes, reset constants and the configuration struct.
// Has no dependencies; every other file of the block imports it.
package wdmc_pkg;

  // Default width of the countdown register.
  localparam int COUNTER_WIDTH_DEF = 32;

  // Field widths of the item and of the configuration registers.
  localparam int MODE_W   = 3;
  localparam int BYTE_W   = 8;
  localparam int MARGIN_W = 16;
  localparam int TPS_W    = 10;
  localparam int STATUS_W = 2;
  localparam int PROD_W   = MARGIN_W + TPS_W;

  // Packed widths of the stream data buses (whole bytes).
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 24;

  // Configuration port.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = TPS_W;

  localparam logic [CFG_INDEX_W-1:0] CFG_NO_WAY_OUT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_NO_REBOOT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TPS        = 2'd2;

  // Reset values and the magic byte.
  localparam logic [TPS_W-1:0]    TPS_RESET      = 10'd100;
  localparam logic [MARGIN_W-1:0] DEFAULT_MARGIN = 16'd60;
  localparam logic [BYTE_W-1:0]   MAGIC_BYTE     = 8'h56;

  // Event selector carried with each input item.
  typedef enum logic [MODE_W-1:0] {
    MODE_TICK      = 3'd0,
    MODE_OPEN      = 3'd1,
    MODE_WRITE     = 3'd2,
    MODE_RELEASE   = 3'd3,
    MODE_KEEPALIVE = 3'd4,
    MODE_SET_TO    = 3'd5,
    MODE_GET_TO    = 3'd6
  } mode_t;

  // Status returned with each result item.
  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_BUSY        = 2'd1,
    STATUS_BAD_TIMEOUT = 2'd2
  } status_t;

  // Configuration as seen by the core.
  typedef struct packed {
    logic             no_way_out;
    logic             no_reboot;
    logic [TPS_W-1:0] ticks_per_second;
  } cfg_t;

endpackage

>>> rtl/wdmc_cfg_regs.sv
// Configuration registers of the watchdog: no_way_out, no_reboot and
// ticks_per_second, written over a valid/ready channel. Uses wdmc_pkg.
module wdmc_cfg_regs import wdmc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output cfg_t                   cfg
);

  // The registers can take a write in every cycle.
  assign cfg_ready = 1'b1;

  // Register write; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_way_out       <= 1'b0;
      cfg.no_reboot        <= 1'b0;
      cfg.ticks_per_second <= TPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_NO_WAY_OUT: cfg.no_way_out       <= cfg_data[0];
        CFG_NO_REBOOT:  cfg.no_reboot        <= cfg_data[0];
        CFG_TPS:        cfg.ticks_per_second <= cfg_data;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/wdmc_reload.sv
// Reload value of the countdown: margin times ticks per second, saturated
// to the countdown width. Purely combinational. Uses wdmc_pkg.
module wdmc_reload import wdmc_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic [MARGIN_W-1:0]      margin,
  input  logic [TPS_W-1:0]         ticks_per_second,
  output logic [COUNTER_WIDTH-1:0] reload_count
);

  logic [PROD_W-1:0] product;

  // One 16 by 10 bit multiplier.
  assign product = PROD_W'(margin) * PROD_W'(ticks_per_second);

  // Saturate only when the countdown is narrower than the product.
  generate
    if (COUNTER_WIDTH >= PROD_W) begin : g_wide
      assign reload_count = COUNTER_WIDTH'(product);
    end else begin : g_narrow
      assign reload_count = (product[PROD_W-1:COUNTER_WIDTH] != '0) ?
                            {COUNTER_WIDTH{1'b1}} : product[COUNTER_WIDTH-1:0];
    end
  endgenerate

endmodule

>>> rtl/wdmc_core.sv
// Core of the watchdog: input register, watchdog state, event decode and
// result register. Depends on wdmc_pkg and wdmc_reload.
module wdmc_core import wdmc_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [MODE_W-1:0]     in_mode,
  input  logic [BYTE_W-1:0]     in_byte,
  input  logic                  in_first,
  input  logic [MARGIN_W-1:0]   in_timeout,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   out_status,
  output logic [MARGIN_W-1:0]   out_timeout,
  output logic                  out_fired,
  output logic                  out_reboot
);

  // Input register.
  logic                held;
  logic [MODE_W-1:0]   held_mode;
  logic [BYTE_W-1:0]   held_byte;
  logic                held_first;
  logic [MARGIN_W-1:0] held_timeout;

  // Watchdog state.
  logic                     is_open, is_open_next;
  logic                     running, running_next;
  logic                     close_armed, close_armed_next;
  logic [MARGIN_W-1:0]      margin_seconds, margin_seconds_next;
  logic [COUNTER_WIDTH-1:0] countdown, countdown_next;

  // Result of the item in the input register.
  logic [STATUS_W-1:0] status_next;
  logic [MARGIN_W-1:0] timeout_next;
  logic                fired_next;
  logic                reboot_next;

  logic                     advance;
  logic [MARGIN_W-1:0]      reload_margin;
  logic [COUNTER_WIDTH-1:0] reload_count;

  // The held item is processed when the result register is free or drains.
  assign advance  = held && (!out_valid || out_ready);
  assign in_ready = !held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (advance) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_mode    <= in_mode;
      held_byte    <= in_byte;
      held_first   <= in_first;
      held_timeout <= in_timeout;
    end
  end

  // A set-timeout reload uses the new margin at once.
  assign reload_margin = (mode_t'(held_mode) == MODE_SET_TO) ? held_timeout : margin_seconds;

  wdmc_reload #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_reload (
    .margin           (reload_margin),
    .ticks_per_second (cfg.ticks_per_second),
    .reload_count     (reload_count)
  );

  // Event decode and next state.
  always_comb begin
    is_open_next        = is_open;
    running_next        = running;
    close_armed_next    = close_armed;
    margin_seconds_next = margin_seconds;
    countdown_next      = countdown;
    status_next         = STATUS_OK;
    timeout_next        = '0;
    fired_next          = 1'b0;
    reboot_next         = 1'b0;
    case (mode_t'(held_mode))
      MODE_TICK: begin
        if (running) begin
          if (countdown > COUNTER_WIDTH'(1)) begin
            countdown_next = countdown - COUNTER_WIDTH'(1);
          end else begin
            countdown_next = '0;
            running_next   = 1'b0;
            fired_next     = 1'b1;
            reboot_next    = !cfg.no_reboot;
          end
        end
      end
      MODE_OPEN: begin
        if (is_open) begin
          status_next = STATUS_BUSY;
        end else begin
          is_open_next   = 1'b1;
          countdown_next = reload_count;
          running_next   = 1'b1;
        end
      end
      MODE_WRITE: begin
        if (!cfg.no_way_out) begin
          if (held_byte == MAGIC_BYTE) begin
            close_armed_next = 1'b1;
          end else if (held_first) begin
            close_armed_next = 1'b0;
          end
        end
        countdown_next = reload_count;
        running_next   = 1'b1;
      end
      MODE_RELEASE: begin
        if (close_armed) begin
          running_next = 1'b0;
        end
        is_open_next     = 1'b0;
        close_armed_next = 1'b0;
      end
      MODE_KEEPALIVE: begin
        countdown_next = reload_count;
        running_next   = 1'b1;
      end
      MODE_SET_TO: begin
        if (held_timeout == '0) begin
          status_next = STATUS_BAD_TIMEOUT;
        end else begin
          margin_seconds_next = held_timeout;
          countdown_next      = reload_count;
          running_next        = 1'b1;
          timeout_next        = held_timeout;
        end
      end
      MODE_GET_TO: begin
        timeout_next = margin_seconds;
      end
      default: begin
      end
    endcase
  end

  // State update, once per processed item.
  always_ff @(posedge clk) begin
    if (rst) begin
      is_open        <= 1'b0;
      running        <= 1'b0;
      close_armed    <= 1'b0;
      margin_seconds <= DEFAULT_MARGIN;
      countdown      <= '0;
    end else if (advance) begin
      is_open        <= is_open_next;
      running        <= running_next;
      close_armed    <= close_armed_next;
      margin_seconds <= margin_seconds_next;
      countdown      <= countdown_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_status  <= status_next;
      out_timeout <= timeout_next;
      out_fired   <= fired_next;
      out_reboot  <= reboot_next;
    end
  end

endmodule

>>> rtl/watchdog_timer_magic_close_unit.sv
// Top level of the watchdog timer with magic close: stream ports,
// configuration port, register file and core. Depends on wdmc_pkg,
// wdmc_cfg_regs and wdmc_core.
//
//   Channel  Direction  Handshake            Payload
//   s_*      in         s_tvalid / s_tready  s_tuser mode, s_tdata item fields
//   m_*      out        m_tvalid / m_tready  m_tdata result fields
//   cfg_*    in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// Each item passes through the input register and then the result register
// of the core, whose state update (one 16 by 10 bit multiply for the
// reload) sets a sustained rate of one item per cycle while m_tready is high.
// Reset is synchronous and clears the state to closed, stopped, margin 60.
// A stalled result holds the result register; the input register then
// holds one further item and s_tready falls until the result is taken.
module watchdog_timer_magic_close_unit import wdmc_pkg::*; #(
  parameter int COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // s_tdata: data_byte[7:0], first_byte[8], new_timeout[24:9], zeros[31:25]
  input  logic [IN_DATA_W-1:0]   s_tdata,
  // s_tuser: mode[2:0]
  input  logic [MODE_W-1:0]      s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // m_tdata: status[1:0], timeout_value[17:2], fired[18],
  //          reboot_request[19], zeros[23:20]
  output logic [OUT_DATA_W-1:0]  m_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t                cfg;
  logic [STATUS_W-1:0] status;
  logic [MARGIN_W-1:0] timeout_value;
  logic                fired;
  logic                reboot_request;

  // Configuration registers.
  wdmc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Watchdog core.
  wdmc_core #(
    .COUNTER_WIDTH(COUNTER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_mode     (s_tuser),
    .in_byte     (s_tdata[7:0]),
    .in_first    (s_tdata[8]),
    .in_timeout  (s_tdata[24:9]),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_status  (status),
    .out_timeout (timeout_value),
    .out_fired   (fired),
    .out_reboot  (reboot_request)
  );

  // Pack the result fields, lowest first.
  assign m_tdata = {4'b0000, reboot_request, fired, timeout_value, status};

`ifndef SYNTHESIS
  // A reboot is only ever requested by an expiring tick.
  a_reboot_needs_fire: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && reboot_request |-> fired)
    else $error("reboot request without expiry");

  // An error status never comes with an expiry or a timeout value.
  a_error_is_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (status != STATUS_OK) |-> !fired && (timeout_value == '0))
    else $error("error result carries other fields");

  // A timeout value comes only from a timeout query or update.
  a_timeout_alone: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (timeout_value != '0) |-> !fired && (status == STATUS_OK))
    else $error("timeout value mixed with other results");

  // The input side stalls only behind a result that is not being taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid && !m_tready)
    else $error("input stalled without output backpressure");
`endif

endmodule

>>> tb/sv/tb_top.sv
// Self-checking testbench for watchdog_timer_magic_close_unit: stream items in,
// one result item out per input item, checked against a cycle-free model of the watchdog.
// Depends on wdmc_pkg and the RTL of the block only.
module tb_top import wdmc_pkg::*; ();

  localparam int CW              = COUNTER_WIDTH_DEF;
  localparam int CYCLE_LIMIT     = 200000;
  localparam int RX_HOLD_CYCLES  = 60;
  localparam int ITEMS_PER_PHASE = 80;
  localparam int PHASES          = 6;
  localparam int IDLE_PERCENT    = 11;
  localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

  // Watchdog state mirror: applies each accepted item and keeps the replies it
  // predicts until the block delivers them.
  class watchdog_mirror;
    typedef struct {
      logic [STATUS_W-1:0] status;
      logic [MARGIN_W-1:0] tval;
      logic                fired;
      logic                reboot;
    } reply_t;

    reply_t pending_replies[$];
    int mismatches;

    logic             no_way_out;
    logic             no_reboot;
    logic [TPS_W-1:0] tps;

    logic                is_open;
    logic                running;
    logic                close_armed;
    logic [MARGIN_W-1:0] margin;
    logic [CW-1:0]       countdown;

    function new();
      no_way_out  = 1'b0;
      no_reboot   = 1'b0;
      tps         = TPS_RESET;
      is_open     = 1'b0;
      running     = 1'b0;
      close_armed = 1'b0;
      margin      = DEFAULT_MARGIN;
      countdown   = '0;
      mismatches  = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_NO_WAY_OUT: no_way_out = val[0];
        CFG_NO_REBOOT:  no_reboot = val[0];
        CFG_TPS:        tps = val[TPS_W-1:0];
        default: ;
      endcase
    endfunction

    // Reload the countdown from margin times ticks, saturating at the counter
    // width, and start it.
    function void rearm();
      logic [63:0] prod;
      logic [63:0] cap;
      prod = 64'(margin) * 64'(tps);
      cap = (CW >= 64) ? '1 : ((64'd1 << CW) - 64'd1);
      countdown = (prod > cap) ? CW'(cap) : CW'(prod);
      running = 1'b1;
    endfunction

    function void apply_event(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] wr_byte,
                              logic first, logic [MARGIN_W-1:0] req);
      reply_t r;
      r.status = STATUS_OK;
      r.tval   = '0;
      r.fired  = 1'b0;
      r.reboot = 1'b0;
      case (mode)
        MODE_TICK: begin
          if (running) begin
            if (countdown > 1) begin
              countdown = countdown - 1'b1;
            end else begin
              countdown = '0;
              running = 1'b0;
              r.fired = 1'b1;
              r.reboot = !no_reboot;
            end
          end
        end
        MODE_OPEN: begin
          if (is_open) begin
            r.status = STATUS_BUSY;
          end else begin
            is_open = 1'b1;
            rearm();
          end
        end
        MODE_WRITE: begin
          if (!no_way_out) begin
            if (first) close_armed = 1'b0;
            if (wr_byte == MAGIC_BYTE) close_armed = 1'b1;
          end
          rearm();
        end
        MODE_RELEASE: begin
          if (close_armed) running = 1'b0;
          is_open = 1'b0;
          close_armed = 1'b0;
        end
        MODE_KEEPALIVE: rearm();
        MODE_SET_TO: begin
          if (req == '0) begin
            r.status = STATUS_BAD_TIMEOUT;
          end else begin
            margin = req;
            rearm();
            r.tval = margin;
          end
        end
        MODE_GET_TO: r.tval = margin;
        default: ;
      endcase
      pending_replies.push_back(r);
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    task check_reply(logic [OUT_DATA_W-1:0] d);
      reply_t r;
      if (pending_replies.size() == 0) begin
        report($sformatf("result item %h with none pending", d));
        return;
      end
      r = pending_replies.pop_front();
      if (d[1:0] !== r.status)
        report($sformatf("status %0d, predicted %0d", d[1:0], r.status));
      if (d[17:2] !== r.tval)
        report($sformatf("timeout_value %0d, predicted %0d", d[17:2], r.tval));
      if (d[18] !== r.fired)
        report($sformatf("fired %b, predicted %b", d[18], r.fired));
      if (d[19] !== r.reboot)
        report($sformatf("reboot_request %b, predicted %b", d[19], r.reboot));
      if (d[23:20] !== 4'd0)
        report($sformatf("padding bits %b not zero", d[23:20]));
    endtask
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic [MODE_W-1:0]      s_tuser = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  watchdog_mirror mirror = new();
  bit idle_on = 1'b1;
  bit hold_pending = 1'b0;
  int sent_items = 0;
  int cycles = 0;

  // Settings per random phase; the extremes of every register appear.
  bit               phase_nwo[PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
  bit               phase_nrb[PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
  logic [TPS_W-1:0] phase_tps[PHASES] = '{10'd1, 10'd0, 10'd1023, 10'd2, 10'd1000, 10'd3};

  watchdog_timer_magic_close_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // Cycle count with a hard stop.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) mirror.check_reply(m_tdata);
  end

  // Receiver: random back-pressure, plus a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        m_tready <= 1'b0;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= !(idle_on && ($urandom_range(99) < IDLE_PERCENT));
    end
  end

  // Offer one item and note it in the mirror once accepted.
  task automatic push_event(logic [MODE_W-1:0] mode, logic [BYTE_W-1:0] wr_byte,
                            logic first, logic [MARGIN_W-1:0] req);
    if (idle_on && ($urandom_range(99) < IDLE_PERCENT)) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= mode;
    s_tdata <= {7'd0, req, first, wr_byte};
    do @(posedge clk); while (!s_tready);
    mirror.apply_event(mode, wr_byte, first, req);
    sent_items++;
  endtask

  // Stop offering items and wait for every pending result item.
  task automatic drain();
    s_tvalid <= 1'b0;
    while (mirror.pending_replies.size() != 0) @(posedge clk);
  endtask

  task automatic load_settings(bit nwo, bit nrb, logic [TPS_W-1:0] tps);
    logic [CFG_INDEX_W-1:0] idx[3];
    logic [CFG_DATA_W-1:0]  val[3];
    idx = '{CFG_NO_WAY_OUT, CFG_NO_REBOOT, CFG_TPS};
    val = '{CFG_DATA_W'(nwo), CFG_DATA_W'(nrb), CFG_DATA_W'(tps)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      mirror.set_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [MARGIN_W-1:0] pick_timeout();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 25) return MARGIN_W'($urandom_range(65535));
    return MARGIN_W'($urandom_range(1, 3));
  endfunction

  // One random event; mostly well-formed write calls and ticks with random content.
  task automatic random_event();
    int pick;
    int len;
    logic [BYTE_W-1:0] wr_byte;
    pick = $urandom_range(99);
    if (pick < 42) begin
      push_event(MODE_TICK, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end else if (pick < 57) begin
      len = $urandom_range(1, 4);
      for (int i = 0; i < len; i++) begin
        wr_byte = ($urandom_range(3) == 0) ? MAGIC_BYTE : BYTE_W'($urandom_range(255));
        push_event(MODE_WRITE, wr_byte, i == 0, MARGIN_W'($urandom));
      end
    end else if (pick < 65) begin
      push_event(MODE_OPEN, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end else if (pick < 73) begin
      push_event(MODE_RELEASE, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end else if (pick < 79) begin
      push_event(MODE_KEEPALIVE, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end else if (pick < 90) begin
      push_event(MODE_SET_TO, BYTE_W'($urandom), 1'($urandom), pick_timeout());
    end else if (pick < 96) begin
      push_event(MODE_GET_TO, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end else if (pick < 98) begin
      // A broken write call: a continuation byte with no first byte before it.
      push_event(MODE_WRITE, BYTE_W'($urandom), 1'b0, MARGIN_W'($urandom));
    end else begin
      push_event(MODE_UNUSED, BYTE_W'($urandom), 1'($urandom), MARGIN_W'($urandom));
    end
  endtask

  // Main sequence: reset, directed items, then random phases.
  initial begin
    int target;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed items at the reset settings.
    push_event(MODE_GET_TO, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);      // tick while stopped
    push_event(MODE_RELEASE, 8'h00, 1'b0, 16'h0000);   // release while closed
    push_event(MODE_OPEN, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_OPEN, 8'h00, 1'b0, 16'h0000);      // open while open
    push_event(MODE_WRITE, 8'hFF, 1'b1, 16'hFFFF);
    push_event(MODE_WRITE, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_WRITE, MAGIC_BYTE, 1'b0, 16'h0000);
    push_event(MODE_RELEASE, 8'h00, 1'b0, 16'h0000);   // armed release stops it
    push_event(MODE_SET_TO, 8'h00, 1'b0, 16'h0000);    // invalid timeout
    push_event(MODE_SET_TO, 8'h00, 1'b0, 16'hFFFF);
    push_event(MODE_GET_TO, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_SET_TO, 8'h00, 1'b0, 16'h0001);
    push_event(MODE_KEEPALIVE, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_UNUSED, 8'hFF, 1'b1, 16'hFFFF);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_WRITE, MAGIC_BYTE, 1'b1, 16'h0000);
    push_event(MODE_WRITE, 8'h41, 1'b1, 16'h0000);     // a new write call disarms
    push_event(MODE_RELEASE, 8'h00, 1'b0, 16'h0000);   // unarmed release keeps running
    drain();

    // Expiry with reboot at one tick per second.
    load_settings(1'b0, 1'b0, 10'd1);
    push_event(MODE_SET_TO, 8'h00, 1'b0, 16'h0002);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
    drain();

    // Zero load, no way out and no reboot.
    load_settings(1'b1, 1'b1, 10'd0);
    push_event(MODE_WRITE, MAGIC_BYTE, 1'b1, 16'h0000);
    push_event(MODE_RELEASE, 8'h00, 1'b0, 16'h0000);
    push_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
    drain();

    // Random phases; the sender pauses for every result between phases.
    for (int p = 0; p < PHASES; p++) begin
      load_settings(phase_nwo[p], phase_nrb[p], phase_tps[p]);
      idle_on = (p != 2);
      if (p == 1) hold_pending = 1'b1;
      target = sent_items + ITEMS_PER_PHASE;
      while (sent_items < target) random_event();
      drain();
    end

    idle_on = 1'b1;
    repeat (20) @(posedge clk);
    if (mirror.mismatches == 0 && mirror.pending_replies.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/wdmc_pkg.sv
rtl/wdmc_cfg_regs.sv
rtl/wdmc_reload.sv
rtl/wdmc_core.sv
rtl/watchdog_timer_magic_close_unit.sv
tb/sv/tb_top.sv
